[rtl/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sonar frame delimiter.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  localparam logic [7:0] START_BYTE       = 8'h40;
  localparam logic [7:0] END_BYTE_RESET   = 8'd10;
  localparam logic [7:0] BYPASS_RESET     = 8'h08;
  localparam int         CFG_IDX_W        = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS_TYPE = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_NONE     = 3'd0,
    VERDICT_OK       = 3'd1,
    VERDICT_MISMATCH = 3'd2,
    VERDICT_BADEND   = 3'd3,
    VERDICT_OVERSIZE = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_HEADER = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] end_byte;
    logic [7:0] bypass_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        in_frame;
    logic        frame_end;
    verdict_t    verdict;
    logic [15:0] frame_length;
    logic [7:0]  msg_type;
  } result_t;

  // Returns {is_hex, value} for one ASCII character.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/sfd_in_if.sv]
// ----------------------------------------------------------------------------
// sfd_in_if
// Valid/ready channel that carries one received byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/sfd_out_if.sv]
// ----------------------------------------------------------------------------
// sfd_out_if
// Valid/ready channel that carries one echoed byte with its framing status.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        in_frame;
  logic        frame_end;
  logic [2:0]  verdict;
  logic [15:0] frame_length;
  logic [7:0]  msg_type;

  modport source (output valid, output data_byte, output in_frame, output frame_end,
                  output verdict, output frame_length, output msg_type, input ready);
  modport sink   (input valid, input data_byte, input in_frame, input frame_end,
                  input verdict, input frame_length, input msg_type, output ready);
endinterface

`default_nettype wire

[rtl/sfd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sfd_cfg_regs
// Configuration registers: end byte and bypass message type.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_cfg_regs
  import sfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata,
  output cfg_t                      cfg
);

  logic [7:0] end_byte_r;
  logic [7:0] bypass_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_byte_r    <= END_BYTE_RESET;
      bypass_type_r <= BYPASS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_END_BYTE:    end_byte_r    <= cfg_wdata;
        REG_BYPASS_TYPE: bypass_type_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.end_byte    = end_byte_r;
  assign cfg.bypass_type = bypass_type_r;

endmodule

`default_nettype wire

[rtl/sfd_parser.sv]
// ----------------------------------------------------------------------------
// sfd_parser
// Frame state and the per-byte update that classifies each received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_parser
  import sfd_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 1024
)
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output result_t         res
);

  // Positions inside an accepted frame never exceed MAX_FRAME_BYTES - 1.
  localparam int POS_W = $clog2(MAX_FRAME_BYTES);
  localparam logic [16:0] MAX_LEN = 17'(MAX_FRAME_BYTES);

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      asc_r, asc_nxt;
  logic             stop_r, stop_nxt;
  logic [15:0]      bin_r, bin_nxt;
  logic [7:0]       type_r, type_nxt;
  logic             seen_r, seen_nxt;

  logic [4:0]  hex;
  logic [16:0] last;
  logic [7:0]  last_byte;
  logic        done;
  logic        inf;
  verdict_t    verdict;

  assign hex = hex_digit(rx_byte);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    asc_nxt   = asc_r;
    stop_nxt  = stop_r;
    bin_nxt   = bin_r;
    type_nxt  = type_r;
    seen_nxt  = seen_r;
    done      = 1'b0;
    inf       = 1'b1;
    verdict   = VERDICT_NONE;
    last      = {1'b0, bin_r} + 17'd5;
    last_byte = rx_byte;

    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == START_BYTE) begin
          phase_nxt = PH_HEADER;
          pos_nxt   = POS_W'(1);
          asc_nxt   = 16'd0;
          stop_nxt  = 1'b0;
          bin_nxt   = 16'd0;
          type_nxt  = 8'd0;
          seen_nxt  = 1'b0;
        end else begin
          inf = 1'b0;
        end
      end
      PH_HEADER: begin
        if (pos_r <= POS_W'(4)) begin
          if (!stop_r && hex[4]) begin
            asc_nxt = {asc_r[11:0], hex[3:0]};
          end else begin
            stop_nxt = 1'b1;
          end
        end else if (pos_r == POS_W'(5)) begin
          bin_nxt = {8'd0, rx_byte};
        end else begin
          bin_nxt = {rx_byte, bin_r[7:0]};
          last    = {1'b0, bin_nxt} + 17'd5;
          if (bin_nxt != asc_r) begin
            verdict = VERDICT_MISMATCH;
            done    = 1'b1;
          end else if ({1'b0, bin_nxt} + 17'd6 > MAX_LEN) begin
            verdict = VERDICT_OVERSIZE;
            done    = 1'b1;
          end else if (last <= 17'd6) begin
            // For an empty body the last byte is the low length byte.
            last_byte = (last == 17'd5) ? bin_nxt[7:0] : rx_byte;
            verdict   = (last_byte == cfg.end_byte) ? VERDICT_OK : VERDICT_BADEND;
            done      = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        pos_nxt = pos_r + POS_W'(1);
      end
      PH_BODY: begin
        if (pos_r == POS_W'(10)) begin
          type_nxt = rx_byte;
          seen_nxt = 1'b1;
        end
        if (17'(pos_r) >= last) begin
          verdict = (rx_byte == cfg.end_byte || (seen_nxt && type_nxt == cfg.bypass_type))
                    ? VERDICT_OK : VERDICT_BADEND;
          done    = 1'b1;
        end
        pos_nxt = pos_r + POS_W'(1);
      end
      default: begin
        phase_nxt = PH_HUNT;
        pos_nxt   = '0;
      end
    endcase

    if (done) begin
      phase_nxt = PH_HUNT;
      pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      asc_r   <= 16'd0;
      stop_r  <= 1'b0;
      bin_r   <= 16'd0;
      type_r  <= 8'd0;
      seen_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      asc_r   <= asc_nxt;
      stop_r  <= stop_nxt;
      bin_r   <= bin_nxt;
      type_r  <= type_nxt;
      seen_r  <= seen_nxt;
    end
  end

  assign res.data_byte    = rx_byte;
  assign res.in_frame     = inf;
  assign res.frame_end    = done;
  assign res.verdict      = verdict;
  assign res.frame_length = done ? bin_nxt : 16'd0;
  assign res.msg_type     = (done && seen_nxt) ? type_nxt : 8'd0;

endmodule

`default_nettype wire

[rtl/sfd_out_stage.sv]
// ----------------------------------------------------------------------------
// sfd_out_stage
// Result register that decouples the result channel from the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_out_stage
  import sfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire result_t res_in,
  input  wire logic    out_ready,
  output logic         take,
  output logic         out_valid,
  output result_t      res_out
);

  logic    valid_r;
  result_t res_r;

  // A new item may enter when the register is empty or the held result leaves in the same cycle.
  assign take = in_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

[rtl/sonar_frame_delimiter_top.sv]
// ----------------------------------------------------------------------------
// sonar_frame_delimiter_top
// An accepted byte's result item enters the output register as the byte is taken.
// Throughput: one byte per cycle unless the output stalls; one state update per byte.
// Reset (synchronous, rst_n low): parser returns to hunting, output empties,
// end byte becomes 10 and bypass type 8.
// ----------------------------------------------------------------------------
`default_nettype none

module sonar_frame_delimiter_top
  import sfd_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 1024
)
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  sfd_in_if.sink                    in_ch,
  sfd_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata
);

  // The block echoes every received byte as one result item. While hunting,
  // bytes are flagged as outside a frame until the start character shows up.
  // The header then carries a four-character ASCII hex length and a binary
  // little-endian length; a disagreement or a length plus six above the buffer
  // size ends the candidate frame on its seventh byte. Otherwise the frame runs
  // to its last byte, where the end byte or a bypass message type decides.

  cfg_t    cfg;
  result_t res;
  result_t res_q;
  logic    take;
  logic    out_valid;

  // Config registers; unenforced user rule: written only while no item is in flight.
  sfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Frame state and the combinational classification of the current byte.
  sfd_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (take),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // Output register; the input stays ready while the held item drains.
  sfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .res_in    (res),
    .out_ready (out_ch.ready),
    .take      (take),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  // Ready does not depend on the input valid, only on the output register and out_ch.ready.
  assign in_ch.ready = !out_valid || out_ch.ready;

  assign out_ch.valid        = out_valid;
  assign out_ch.data_byte    = res_q.data_byte;
  assign out_ch.in_frame     = res_q.in_frame;
  assign out_ch.frame_end    = res_q.frame_end;
  assign out_ch.verdict      = res_q.verdict;
  assign out_ch.frame_length = res_q.frame_length;
  assign out_ch.msg_type     = res_q.msg_type;

endmodule

`default_nettype wire

[verif/sonar_frame_delimiter_top_tb.sv]
// ----------------------------------------------------------------------------
// sonar_frame_delimiter_top_tb
// Self-checking bench for the sonar frame delimiter. Byte streams made of
// well-formed frames, broken headers and line noise are fed through the input
// channel. A scoreboard predicts the framing status of every echoed byte and
// compares it with each result item as it leaves the block. The bench runs
// several register settings and several patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sonar_frame_delimiter_top_tb;
  import sfd_pkg::*;

  localparam int MAX_FRAME = 1024;
  // Bytes of random traffic in each stall/register phase.
  localparam int PHASE_BYTES = 212;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the frame parser state and checks the echoed items.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    int          max_bytes;
    logic [7:0]  end_byte;
    logic [7:0]  bypass_type;
    phase_t      ph;
    logic [16:0] pos;
    logic [15:0] ascii_len;
    logic [15:0] bin_len;
    bit          ascii_stop;
    logic [7:0]  type_byte;
    bit          type_seen;
    result_t     expected_q[$];
    int          failures;

    function new(int max_frame_bytes);
      max_bytes   = max_frame_bytes;
      end_byte    = END_BYTE_RESET;
      bypass_type = BYPASS_RESET;
      ph          = PH_HUNT;
      pos         = '0;
      ascii_len   = '0;
      bin_len     = '0;
      ascii_stop  = 1'b0;
      type_byte   = '0;
      type_seen   = 1'b0;
      failures    = 0;
    endfunction

    // Value of an ASCII hex digit, or -1 for any other character.
    function int hex_nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) begin
        return int'(c) - 'h30;
      end
      if (c >= 8'h41 && c <= 8'h46) begin
        return int'(c) - 'h41 + 10;
      end
      if (c >= 8'h61 && c <= 8'h66) begin
        return int'(c) - 'h61 + 10;
      end
      return -1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == REG_END_BYTE) begin
        end_byte = val;
      end else if (idx == REG_BYPASS_TYPE) begin
        bypass_type = val;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advances the parser by one accepted byte and queues its status.
    function void note_byte(logic [7:0] b);
      result_t     r;
      logic [16:0] last_off;
      logic [7:0]  closing;
      int          h;
      bit          done;
      r           = '0;
      r.data_byte = b;
      r.in_frame  = 1'b1;
      r.verdict   = VERDICT_NONE;
      done        = 1'b0;
      case (ph)
        PH_HUNT: begin
          if (b == START_BYTE) begin
            ph         = PH_HEADER;
            pos        = 17'd1;
            ascii_len  = '0;
            ascii_stop = 1'b0;
            bin_len    = '0;
            type_byte  = '0;
            type_seen  = 1'b0;
          end else begin
            r.in_frame = 1'b0;
          end
        end
        PH_HEADER: begin
          if (pos <= 17'd4) begin
            h = hex_nibble(b);
            if (!ascii_stop && h >= 0) begin
              ascii_len = {ascii_len[11:0], h[3:0]};
            end else begin
              ascii_stop = 1'b1;
            end
          end else if (pos == 17'd5) begin
            bin_len = {8'h00, b};
          end else begin
            bin_len[15:8] = b;
            last_off      = {1'b0, bin_len} + 17'd5;
            done          = 1'b1;
            if (bin_len != ascii_len) begin
              r.verdict = VERDICT_MISMATCH;
            end else if (int'(bin_len) + 6 > max_bytes) begin
              r.verdict = VERDICT_OVERSIZE;
            end else if (last_off <= 17'd6) begin
              // The closing byte of a short frame is one of the length bytes.
              closing   = (last_off == 17'd5) ? bin_len[7:0] : b;
              r.verdict = (closing == end_byte) ? VERDICT_OK : VERDICT_BADEND;
            end else begin
              done = 1'b0;
              ph   = PH_BODY;
            end
          end
          pos = pos + 17'd1;
        end
        default: begin
          last_off = {1'b0, bin_len} + 17'd5;
          if (pos == 17'd10) begin
            type_byte = b;
            type_seen = 1'b1;
          end
          if (pos >= last_off) begin
            done = 1'b1;
            if (b == end_byte || (type_seen && type_byte == bypass_type)) begin
              r.verdict = VERDICT_OK;
            end else begin
              r.verdict = VERDICT_BADEND;
            end
          end
          pos = pos + 17'd1;
        end
      endcase
      if (done) begin
        r.frame_end    = 1'b1;
        r.frame_length = bin_len;
        r.msg_type     = type_seen ? type_byte : 8'h00;
        ph             = PH_HUNT;
        pos            = '0;
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: result item with nothing expected, data_byte=%02h",
                   got.data_byte);
        end
        return;
      end
      exp = expected_q.pop_front();
      if (got.data_byte !== exp.data_byte || got.in_frame !== exp.in_frame ||
          got.frame_end !== exp.frame_end || got.verdict !== exp.verdict ||
          got.frame_length !== exp.frame_length || got.msg_type !== exp.msg_type) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: expected byte=%02h in_frame=%0b end=%0b verdict=%0d len=%0d type=%02h",
                   exp.data_byte, exp.in_frame, exp.frame_end, exp.verdict,
                   exp.frame_length, exp.msg_type);
          $display("       actual   byte=%02h in_frame=%0b end=%0b verdict=%0d len=%0d type=%02h",
                   got.data_byte, got.in_frame, got.frame_end, got.verdict,
                   got.frame_length, got.msg_type);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the device under test.
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;

  sfd_in_if  in_ch();
  sfd_out_if out_ch();

  sonar_frame_delimiter_top #(.MAX_FRAME_BYTES(MAX_FRAME)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  frame_scoreboard sb;
  logic [7:0]      frame_q[$];
  int              bytes_sent;
  int              send_idle_pct;
  int              recv_stall_pct;
  bit              hold_req;
  int              hold_left;

  // --------------------------------------------------------------------------
  // Receiver. Ready changes on the falling edge with the stall rate of the
  // current phase. When a hold-off is requested, ready stays low for a long
  // stretch counted here, so the output register fills and the block has to
  // push back on the sender.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 60;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every item that leaves the block is checked at the rising edge that
  // accepts it, against the oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.data_byte    = out_ch.data_byte;
      got.in_frame     = out_ch.in_frame;
      got.frame_end    = out_ch.frame_end;
      got.verdict      = verdict_t'(out_ch.verdict);
      got.frame_length = out_ch.frame_length;
      got.msg_type     = out_ch.msg_type;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. All of them are entered and left just after a falling edge.
  // Valid is only lowered when the sender decides to idle, so a byte that
  // follows another directly keeps valid high without a glitch.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame_q();
    foreach (frame_q[i]) send_byte(frame_q[i]);
    frame_q.delete();
  endtask

  // Appends one byte to the frame being built.
  task automatic queue_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endtask

  // Stops sending and waits until every predicted item has come out. The
  // block makes one item per byte, so a short pause afterwards is enough
  // before touching the registers.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Writes the end byte and then the bypass type back to back; the write enable is
  // raised once and lowered once.
  task automatic write_config(input logic [7:0] end_val, input logic [7:0] bypass_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_END_BYTE;
    cfg_wdata <= end_val;
    @(negedge clk);
    cfg_index <= REG_BYPASS_TYPE;
    cfg_wdata <= bypass_val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_END_BYTE, end_val);
    sb.write_reg(REG_BYPASS_TYPE, bypass_val);
  endtask

  // --------------------------------------------------------------------------
  // Frame builders.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] d, input bit lower);
    if (d < 4'd10) begin
      return 8'h30 + d;
    end
    return (lower ? 8'h61 : 8'h41) + d - 8'd10;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == START_BYTE);
    return c;
  endfunction

  // Start byte, four ASCII hex digits of ascii_val in mixed case, then the
  // little-endian binary length.
  task automatic push_header(input logic [15:0] ascii_val, input logic [15:0] bin_val);
    queue_byte(START_BYTE);
    for (int i = 3; i >= 0; i--) begin
      queue_byte(hex_char(ascii_val[i*4 +: 4], 1'($urandom_range(1))));
    end
    queue_byte(bin_val[7:0]);
    queue_byte(bin_val[15:8]);
  endtask

  // Body bytes from offset 7 to the closing byte. Offset 10 often carries the
  // bypass type and the closing byte is often the end byte, so that every
  // combination of the two shows up, including frames where they coincide.
  task automatic push_body(input logic [15:0] len);
    logic [7:0] c;
    for (int off = 7; off <= int'(len) + 5; off++) begin
      c = 8'($urandom_range(255));
      if (off == 10 && $urandom_range(99) < 40) c = sb.bypass_type;
      if (off == int'(len) + 5 && $urandom_range(99) < 55) c = sb.end_byte;
      queue_byte(c);
    end
  endtask

  task automatic build_random_frame();
    int          pick;
    int          k;
    logic [15:0] len;
    logic [15:0] alt;
    logic [7:0]  c;
    pick = $urandom_range(99);
    if (pick < 58) begin
      // Well-formed frame, mostly short.
      k = $urandom_range(99);
      if (k < 75) len = 16'($urandom_range(14));
      else if (k < 97) len = 16'($urandom_range(40, 15));
      else len = 16'($urandom_range(120, 41));
      push_header(len, len);
      push_body(len);
    end else if (pick < 68) begin
      // The ASCII length stops early at a non-hex character; later
      // characters may be hex and must be ignored.
      k   = $urandom_range(3);
      len = (k == 0) ? 16'd0 : 16'($urandom_range((k == 1) ? 15 : 40));
      queue_byte(START_BYTE);
      for (int i = k - 1; i >= 0; i--) begin
        queue_byte(hex_char(len[i*4 +: 4], 1'($urandom_range(1))));
      end
      do c = 8'($urandom_range(255)); while (sb.hex_nibble(c) >= 0);
      queue_byte(c);
      for (int i = k + 1; i < 4; i++) queue_byte(8'($urandom_range(255)));
      alt = ($urandom_range(99) < 80) ? len : 16'($urandom_range(40));
      queue_byte(alt[7:0]);
      queue_byte(alt[15:8]);
      if (alt == len) push_body(len);
    end else if (pick < 78) begin
      // ASCII and binary lengths disagree in one bit.
      len = ($urandom_range(1) != 0) ? 16'($urandom_range(30)) : 16'($urandom_range(65535));
      alt = len ^ (16'd1 << $urandom_range(15));
      if ($urandom_range(1) != 0) push_header(len, alt);
      else push_header(alt, len);
    end else if (pick < 86) begin
      // Oversize, with the smallest oversize length and the largest length favored.
      k = $urandom_range(9);
      if (k < 3) len = 16'(MAX_FRAME - 5);
      else if (k == 3) len = 16'hFFFF;
      else len = 16'($urandom_range(65535, MAX_FRAME - 5));
      push_header(len, len);
    end else if (pick < 93) begin
      repeat ($urandom_range(6, 1)) queue_byte(noise_byte());
    end else begin
      // Truncated header; the next start byte is swallowed by it.
      queue_byte(START_BYTE);
      repeat ($urandom_range(5)) queue_byte(hex_char(4'($urandom_range(15)), 1'b0));
    end
    if ($urandom_range(99) < 40) begin
      repeat ($urandom_range(3, 1)) queue_byte(noise_byte());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int  phase_start;
    bit  drained;
    sb             = new(MAX_FRAME);
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_END_BYTE;
    cfg_wdata      = 8'h00;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    bytes_sent     = 0;
    drained        = 1'b0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed bytes with the reset register values (end byte 10, bypass 8):
    // noise at both extremes and just above the start byte, then an oversize
    // frame of the largest length, a one-byte frame whose closing byte is the
    // high length byte, and an ASCII length cut short by an "0x" prefix.
    frame_q = {8'h00, 8'hFF, 8'h41,
               START_BYTE, 8'h66, 8'h66, 8'h46, 8'h46, 8'hFF, 8'hFF,
               START_BYTE, 8'h30, 8'h30, 8'h30, 8'h31, 8'h01, 8'h00,
               START_BYTE, 8'h30, 8'h78, 8'h31, 8'h32, 8'h00, 8'h00};
    send_frame_q();

    // Four phases, each with its own register values and stall pattern.
    // The first runs flat out and includes a long receiver hold-off; the
    // second has an idle sender and one full drain midway; the third a
    // stalling receiver; the last both, plus one long frame.
    for (int stage = 0; stage < 4; stage++) begin
      wait_idle();
      case (stage)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_config(8'h00, 8'hFF);
        end
        1: begin
          send_idle_pct  = 65;
          recv_stall_pct = 0;
          write_config(8'hFF, 8'h00);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 65;
          write_config(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
          write_config(END_BYTE_RESET, BYPASS_RESET);
        end
      endcase
      phase_start = bytes_sent;
      if (stage == 0) hold_req = 1'b1;
      if (stage == 3) begin
        push_header(16'd200, 16'd200);
        push_body(16'd200);
        send_frame_q();
      end
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_random_frame();
        send_frame_q();
        if (stage == 1 && !drained && bytes_sent - phase_start > PHASE_BYTES / 2) begin
          wait_idle();
          drained = 1'b1;
        end
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest legal run of about a thousand bytes.
  initial begin
    #(20 * 400000);
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

[sonar_frame_delimiter_top.f]
rtl/sfd_pkg.sv
rtl/sfd_in_if.sv
rtl/sfd_out_if.sv
rtl/sfd_cfg_regs.sv
rtl/sfd_parser.sv
rtl/sfd_out_stage.sv
rtl/sonar_frame_delimiter_top.sv
verif/sonar_frame_delimiter_top_tb.sv
